// File: rtl/fmms_pkg.sv
// ----------------------------------------------------------------------------
// fmms_pkg
// Types and constants shared by the feature min-max scaler and its channels.
// ----------------------------------------------------------------------------
package fmms_pkg;

  localparam int FEATURES = 4096;
  localparam int FEAT_AW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int IDX_W    = 12;
  localparam int VAL_W    = 16;
  localparam int SCL_W    = 17;

  localparam logic [16:0] FEATURES_L = 17'(FEATURES);
  localparam logic [FEAT_AW-1:0] LAST_ADDR = FEAT_AW'(FEATURES - 1);

  localparam logic signed [VAL_W-1:0] MIN_INIT = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] MAX_INIT = 16'sh8000;

  localparam logic [SCL_W-1:0] SCALE_ZERO = 17'h00000;
  localparam logic [SCL_W-1:0] SCALE_ONE  = 17'h10000;

  localparam logic MODE_OBSERVE   = 1'b0;
  localparam logic MODE_NORMALIZE = 1'b1;

  localparam logic [4:0] DIV_LAST_BIT = 5'd16;

  typedef struct packed {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
  } fmms_row_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DIV,
    ST_OUT
  } fmms_state_t;

endpackage

// File: rtl/fmms_in_if.sv
// ----------------------------------------------------------------------------
// fmms_in_if
// Sample channel: valid/ready with mode, feature index and Q8.8 sample.
// ----------------------------------------------------------------------------
interface fmms_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [fmms_pkg::IDX_W-1:0]         feature_index;
  logic signed [fmms_pkg::VAL_W-1:0]  sample_value;

  modport source (output valid, output mode, output feature_index,
                  output sample_value, input ready);
  modport sink   (input valid, input mode, input feature_index,
                  input sample_value, output ready);
endinterface

// File: rtl/fmms_out_if.sv
// ----------------------------------------------------------------------------
// fmms_out_if
// Result channel: valid/ready with 1.16 scaled value and range flag.
// ----------------------------------------------------------------------------
interface fmms_out_if;
  logic                        valid;
  logic                        ready;
  logic [fmms_pkg::SCL_W-1:0]  scaled_value;
  logic                        out_of_range;

  modport source (output valid, output scaled_value, output out_of_range,
                  input ready);
  modport sink   (input valid, input scaled_value, input out_of_range,
                  output ready);
endinterface

// File: rtl/feature_minmax_scaling.sv
// ----------------------------------------------------------------------------
// feature_minmax_scaling
// Per-feature min-max scaler with a bit-serial restoring divider.
//
//   channel   dir  beat contents
//   in_bus    in   mode, feature_index, sample_value
//   out_bus   out  scaled_value, out_of_range (normalize beats only)
//
// An observe beat reads the table row and then writes it back updated. A
// normalize beat reads the row and evaluates it; when the result is fixed by
// the bounds it goes straight to the output step, else it first runs 17
// divider steps (one quotient bit each) and then the output step.
// After reset a clearing pass writes every table row, with in_bus.ready low.
// The result sits in an output register, so the next beat is taken while it
// waits; a stalled result holds only a later result.
// ----------------------------------------------------------------------------
module feature_minmax_scaling (
  input  logic clk,
  input  logic rst_n,
  fmms_in_if.sink    in_bus,
  fmms_out_if.source out_bus
);
  import fmms_pkg::*;

  fmms_row_t mem [FEATURES];

  fmms_state_t         state_r, state_nxt;
  logic [FEAT_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic                mode_r, mode_nxt;
  logic                idx_ok_r, idx_ok_nxt;
  logic [FEAT_AW-1:0]  addr_r, addr_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  fmms_row_t           rd_data_r;
  logic [SCL_W-1:0]    rem_r, rem_nxt;
  logic [VAL_W-1:0]    div_r, div_nxt;
  logic [SCL_W-1:0]    q_r, q_nxt;
  logic                flag_r, flag_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SCL_W-1:0]    out_scaled_r, out_scaled_nxt;
  logic                out_oor_r, out_oor_nxt;

  logic                in_fire;
  logic [FEAT_AW-1:0]  rd_addr;
  logic                mem_we;
  logic [FEAT_AW-1:0]  mem_wa;
  fmms_row_t           mem_wd;
  logic [SCL_W:0]      diff;
  logic                ge;

  assign in_bus.ready         = (state_r == ST_IDLE);
  assign in_fire              = in_bus.valid && in_bus.ready;
  assign rd_addr              = FEAT_AW'(in_bus.feature_index);
  assign out_bus.valid        = out_valid_r;
  assign out_bus.scaled_value = out_scaled_r;
  assign out_bus.out_of_range = out_oor_r;

  assign diff = {1'b0, rem_r} - {2'b00, div_r};
  assign ge   = !diff[SCL_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_fire) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    mode_nxt       = mode_r;
    idx_ok_nxt     = idx_ok_r;
    addr_nxt       = addr_r;
    val_nxt        = val_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    flag_nxt       = flag_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_scaled_nxt = out_scaled_r;
    out_oor_nxt    = out_oor_r;
    mem_we         = 1'b0;
    mem_wa         = addr_r;
    mem_wd         = rd_data_r;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_r;
        mem_wd.lo = MIN_INIT;
        mem_wd.hi = MAX_INIT;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_bus.mode;
          idx_ok_nxt = {5'b00000, in_bus.feature_index} < FEATURES_L;
          addr_nxt   = rd_addr;
          val_nxt    = in_bus.sample_value;
          state_nxt  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (mode_r == MODE_OBSERVE) begin
          mem_we = idx_ok_r;
          if (val_r < rd_data_r.lo) begin
            mem_wd.lo = val_r;
          end
          if (val_r > rd_data_r.hi) begin
            mem_wd.hi = val_r;
          end
          state_nxt = ST_IDLE;
        end else begin
          q_nxt     = SCALE_ZERO;
          flag_nxt  = 1'b0;
          div_nxt   = rd_data_r.hi - rd_data_r.lo;
          rem_nxt   = {1'b0, 16'(val_r - rd_data_r.lo)};
          cnt_nxt   = DIV_LAST_BIT;
          state_nxt = ST_OUT;
          priority if (!idx_ok_r || (rd_data_r.hi <= rd_data_r.lo)) begin
            q_nxt = SCALE_ZERO;
          end else if (val_r < rd_data_r.lo) begin
            flag_nxt = 1'b1;
          end else if (val_r > rd_data_r.hi) begin
            q_nxt    = SCALE_ONE;
            flag_nxt = 1'b1;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        q_nxt   = {q_r[SCL_W-2:0], ge};
        rem_nxt = ge ? {diff[VAL_W-1:0], 1'b0} : {rem_r[VAL_W-1:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 5'd0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_valid_nxt  = 1'b1;
          out_scaled_nxt = q_r;
          out_oor_nxt    = flag_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    idx_ok_r     <= idx_ok_nxt;
    addr_r       <= addr_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    q_r          <= q_nxt;
    flag_r       <= flag_nxt;
    cnt_r        <= cnt_nxt;
    out_scaled_r <= out_scaled_nxt;
    out_oor_r    <= out_oor_nxt;
  end

endmodule
